/* hdl/amix_pkg.sv */
// Package for the affine matrix inverse: beat types and fixed constants.
// Used by affine_matrix_inverse_top and amix_checker; depends on nothing.
`default_nettype none

package amix_pkg;

    // Element width of every input and output element.
    localparam int DATA_W = 32;

    // Row numbers carried in row_index.
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] a00;
        logic signed [DATA_W-1:0] a01;
        logic signed [DATA_W-1:0] a02;
        logic signed [DATA_W-1:0] a03;
        logic signed [DATA_W-1:0] a10;
        logic signed [DATA_W-1:0] a11;
        logic signed [DATA_W-1:0] a12;
        logic signed [DATA_W-1:0] a13;
        logic signed [DATA_W-1:0] a20;
        logic signed [DATA_W-1:0] a21;
        logic signed [DATA_W-1:0] a22;
        logic signed [DATA_W-1:0] a23;
    } mat_beat_t;

    typedef struct packed {
        logic [1:0]               row_index;
        logic signed [DATA_W-1:0] col0;
        logic signed [DATA_W-1:0] col1;
        logic signed [DATA_W-1:0] col2;
        logic signed [DATA_W-1:0] col3;
        logic                     singular;
        logic                     last_row;
    } row_beat_t;

endpackage

`default_nettype wire

/* hdl/affine_matrix_inverse_top.sv */
// Stages: 4 matrix stages, 1 row serializer stage, 4 row stages, DATA_W+2 divider
// stages and the output register. Throughput: one row beat every cycle unless
// row_stall holds the output; the row serializer sends the three rows of a matrix
// one per cycle and takes a new matrix only once the last of them has left.
// Reset (rst_n, asynchronous, active low) clears all valid bits and the serializer.
// Top level of the affine matrix inverse; uses amix_pkg.
`default_nettype none

module affine_matrix_inverse_top
    import amix_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mat_valid,
    output logic      mat_stall,
    input  mat_beat_t mat,
    output logic      row_valid,
    input  logic      row_stall,
    output row_beat_t row
);

    // Widths. Cofactors are exact differences of two element products, the determinant
    // and the translation numerator exact sums of three element-cofactor products.
    localparam int W  = DATA_W;
    localparam int CW = 2 * W + 1;
    localparam int PW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int TW = 3 * W + 3;
    localparam int NE = CW + 2 * FRAC_BITS;
    localparam int NT = TW + FRAC_BITS + 1;
    localparam int NW = (NE > NT) ? NE : NT;
    localparam int MW = (NW > DW) ? NW : DW;
    localparam int RW = MW + W + 2;
    // Divider stages: stage 0 holds the start value, then one quotient bit per
    // stage from bit W (overflow) down to bit 0.
    localparam int NS = W + 2;

    // Round-half-away division result: q is floor((2|n|+|d|)/(2|d|)), bit W
    // flags a quotient beyond the element range. Saturate and apply the sign.
    function automatic logic [W-1:0] sat_q(input logic [W:0] q, input logic neg);
        logic [W-1:0] lim;
        lim = {1'b1, {(W-1){1'b0}}};
        if (neg)
        begin
            if (q[W] || (q[W-1:0] > lim))
                return lim;
            return (~q[W-1:0]) + W'(1);
        end
        if (q[W] || q[W-1])
            return {1'b0, {(W-1){1'b1}}};
        return q[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Matrix stages. Stage 1 forms the eighteen cofactor products, stage 2
    // the nine cofactors, stage 3 the determinant partial products (each
    // cofactor split into a low and a high half), stage 4 the determinant.
    // ------------------------------------------------------------------
    logic                 p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic                 en_p1, en_p2, en_p3, en_p4;
    logic signed [2*W-1:0] p1_pos_reg [9];
    logic signed [2*W-1:0] p1_neg_reg [9];
    logic signed [W-1:0]  p1_lin_reg [3];
    logic signed [W-1:0]  p1_tr_reg [3];
    logic signed [CW-1:0] p2_c_reg [9];
    logic signed [W-1:0]  p2_lin_reg [3];
    logic signed [W-1:0]  p2_tr_reg [3];
    logic signed [PW-1:0] p3_dl_reg [3];
    logic signed [PW-1:0] p3_dh_reg [3];
    logic signed [CW-1:0] p3_c_reg [9];
    logic signed [W-1:0]  p3_tr_reg [3];
    logic signed [DW-1:0] p4_det_reg;
    logic signed [CW-1:0] p4_c_reg [9];
    logic signed [W-1:0]  p4_tr_reg [3];

    // Serializer: holds one matrix and issues its three rows.
    logic                 s_v_reg;
    logic [1:0]           s_cnt_reg;
    logic                 s_free;
    logic signed [CW-1:0] s_c_reg [9];
    logic signed [W-1:0]  s_tr_reg [3];
    logic signed [DW-1:0] s_det_reg;
    logic                 s_zero_reg;
    logic signed [CW-1:0] sel_c [3];

    // Row stages.
    logic                 r0_v_reg, r1_v_reg, r2_v_reg, r3_v_reg;
    logic                 en_r0, en_r1, en_r2, en_r3;
    logic signed [CW-1:0] r0_c_reg [3];
    logic signed [W-1:0]  r0_tr_reg [3];
    logic signed [DW-1:0] r0_det_reg;
    logic                 r0_zero_reg;
    logic [1:0]           r0_idx_reg;
    logic signed [PW-1:0] r1_tl_reg [3];
    logic signed [PW-1:0] r1_th_reg [3];
    logic signed [CW-1:0] r1_c_reg [3];
    logic signed [DW-1:0] r1_det_reg;
    logic                 r1_zero_reg;
    logic [1:0]           r1_idx_reg;
    logic signed [TW-1:0] r2_tnum_reg;
    logic signed [CW-1:0] r2_c_reg [3];
    logic signed [DW-1:0] r2_det_reg;
    logic                 r2_zero_reg;
    logic [1:0]           r2_idx_reg;
    logic [NW-1:0]        r3_absn_reg [4];
    logic [DW-1:0]        r3_absd_reg;
    logic                 r3_neg_reg [4];
    logic                 r3_zero_reg;
    logic [1:0]           r3_idx_reg;

    // Divider stages.
    logic                 d_v_reg [NS];
    logic                 en_d [NS];
    logic [RW-1:0]        d_rem_reg [NS][4];
    logic [W:0]           d_q_reg [NS][4];
    logic [RW-1:0]        d_bot_reg [NS];
    logic                 d_neg_reg [NS][4];
    logic                 d_zero_reg [NS];
    logic [1:0]           d_idx_reg [NS];

    // Output register.
    logic                 o_v_reg;
    logic                 en_o;
    row_beat_t            o_beat_reg;

    // ------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or its content moves on,
    // so bubbles close up even while the output beat waits.
    // ------------------------------------------------------------------
    assign en_o = !o_v_reg || !row_stall;
    assign en_d[NS-1] = !d_v_reg[NS-1] || en_o;
    for (genvar s = 0; s < NS - 1; s++)
    begin : g_en_d
        assign en_d[s] = !d_v_reg[s] || en_d[s+1];
    end
    assign en_r3 = !r3_v_reg || en_d[0];
    assign en_r2 = !r2_v_reg || en_r3;
    assign en_r1 = !r1_v_reg || en_r2;
    assign en_r0 = !r0_v_reg || en_r1;

    // The serializer takes a new matrix once its last row has left.
    assign s_free = !s_v_reg || ((s_cnt_reg == ROW_LAST) && en_r0);
    assign en_p4 = !p4_v_reg || s_free;
    assign en_p3 = !p3_v_reg || en_p4;
    assign en_p2 = !p2_v_reg || en_p3;
    assign en_p1 = !p1_v_reg || en_p2;
    assign mat_stall = !en_p1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            s_v_reg   <= 1'b0;
            s_cnt_reg <= ROW_FIRST;
            r0_v_reg  <= 1'b0;
            r1_v_reg  <= 1'b0;
            r2_v_reg  <= 1'b0;
            r3_v_reg  <= 1'b0;
            for (int s = 0; s < NS; s++)
                d_v_reg[s] <= 1'b0;
            o_v_reg   <= 1'b0;
        end
        else
        begin
            if (en_p1) p1_v_reg <= mat_valid;
            if (en_p2) p2_v_reg <= p1_v_reg;
            if (en_p3) p3_v_reg <= p2_v_reg;
            if (en_p4) p4_v_reg <= p3_v_reg;
            if (s_free)
            begin
                s_v_reg   <= p4_v_reg;
                s_cnt_reg <= ROW_FIRST;
            end
            else if (en_r0)
            begin
                s_cnt_reg <= s_cnt_reg + 2'd1;
            end
            if (en_r0) r0_v_reg <= s_v_reg;
            if (en_r1) r1_v_reg <= r0_v_reg;
            if (en_r2) r2_v_reg <= r1_v_reg;
            if (en_r3) r3_v_reg <= r2_v_reg;
            if (en_d[0]) d_v_reg[0] <= r3_v_reg;
            for (int s = 1; s < NS; s++)
                if (en_d[s]) d_v_reg[s] <= d_v_reg[s-1];
            if (en_o) o_v_reg <= d_v_reg[NS-1];
        end
    end

    // ------------------------------------------------------------------
    // Matrix datapath.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en_p1)
        begin
            p1_pos_reg[0] <= mat.a11 * mat.a22;  p1_neg_reg[0] <= mat.a12 * mat.a21;
            p1_pos_reg[1] <= mat.a02 * mat.a21;  p1_neg_reg[1] <= mat.a01 * mat.a22;
            p1_pos_reg[2] <= mat.a01 * mat.a12;  p1_neg_reg[2] <= mat.a02 * mat.a11;
            p1_pos_reg[3] <= mat.a12 * mat.a20;  p1_neg_reg[3] <= mat.a10 * mat.a22;
            p1_pos_reg[4] <= mat.a00 * mat.a22;  p1_neg_reg[4] <= mat.a02 * mat.a20;
            p1_pos_reg[5] <= mat.a02 * mat.a10;  p1_neg_reg[5] <= mat.a00 * mat.a12;
            p1_pos_reg[6] <= mat.a10 * mat.a21;  p1_neg_reg[6] <= mat.a11 * mat.a20;
            p1_pos_reg[7] <= mat.a01 * mat.a20;  p1_neg_reg[7] <= mat.a00 * mat.a21;
            p1_pos_reg[8] <= mat.a00 * mat.a11;  p1_neg_reg[8] <= mat.a01 * mat.a10;
            p1_lin_reg[0] <= mat.a00;
            p1_lin_reg[1] <= mat.a01;
            p1_lin_reg[2] <= mat.a02;
            p1_tr_reg[0]  <= mat.a03;
            p1_tr_reg[1]  <= mat.a13;
            p1_tr_reg[2]  <= mat.a23;
        end
        if (en_p2)
        begin
            for (int k = 0; k < 9; k++)
                p2_c_reg[k] <= CW'(p1_pos_reg[k]) - CW'(p1_neg_reg[k]);
            p2_lin_reg <= p1_lin_reg;
            p2_tr_reg  <= p1_tr_reg;
        end
        if (en_p3)
        begin
            // Determinant terms a0j * c[j][0], cofactor split at bit W.
            for (int j = 0; j < 3; j++)
            begin
                p3_dl_reg[j] <= PW'(p2_lin_reg[j]) * $signed({1'b0, p2_c_reg[3*j][W-1:0]});
                p3_dh_reg[j] <= PW'(p2_lin_reg[j]) * PW'($signed(p2_c_reg[3*j][CW-1:W]));
            end
            p3_c_reg  <= p2_c_reg;
            p3_tr_reg <= p2_tr_reg;
        end
        if (en_p4)
        begin
            p4_det_reg <= (DW'(p3_dh_reg[0]) <<< W) + DW'(p3_dl_reg[0])
                        + (DW'(p3_dh_reg[1]) <<< W) + DW'(p3_dl_reg[1])
                        + (DW'(p3_dh_reg[2]) <<< W) + DW'(p3_dl_reg[2]);
            p4_c_reg  <= p3_c_reg;
            p4_tr_reg <= p3_tr_reg;
        end
        if (s_free)
        begin
            s_c_reg    <= p4_c_reg;
            s_tr_reg   <= p4_tr_reg;
            s_det_reg  <= p4_det_reg;
            s_zero_reg <= (p4_det_reg == '0);
        end
    end

    // Cofactors of the row being issued.
    always_comb
    begin
        unique case (s_cnt_reg)
            ROW_FIRST:
            begin
                sel_c[0] = s_c_reg[0];
                sel_c[1] = s_c_reg[1];
                sel_c[2] = s_c_reg[2];
            end
            ROW_SECOND:
            begin
                sel_c[0] = s_c_reg[3];
                sel_c[1] = s_c_reg[4];
                sel_c[2] = s_c_reg[5];
            end
            default:
            begin
                sel_c[0] = s_c_reg[6];
                sel_c[1] = s_c_reg[7];
                sel_c[2] = s_c_reg[8];
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Row datapath: translation numerator, then operand preparation.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en_r0)
        begin
            r0_c_reg    <= sel_c;
            r0_tr_reg   <= s_tr_reg;
            r0_det_reg  <= s_det_reg;
            r0_zero_reg <= s_zero_reg;
            r0_idx_reg  <= s_cnt_reg;
        end
        if (en_r1)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r1_tl_reg[j] <= PW'(r0_tr_reg[j]) * $signed({1'b0, r0_c_reg[j][W-1:0]});
                r1_th_reg[j] <= PW'(r0_tr_reg[j]) * PW'($signed(r0_c_reg[j][CW-1:W]));
            end
            r1_c_reg    <= r0_c_reg;
            r1_det_reg  <= r0_det_reg;
            r1_zero_reg <= r0_zero_reg;
            r1_idx_reg  <= r0_idx_reg;
        end
        if (en_r2)
        begin
            r2_tnum_reg <= (TW'(r1_th_reg[0]) <<< W) + TW'(r1_tl_reg[0])
                         + (TW'(r1_th_reg[1]) <<< W) + TW'(r1_tl_reg[1])
                         + (TW'(r1_th_reg[2]) <<< W) + TW'(r1_tl_reg[2]);
            r2_c_reg    <= r1_c_reg;
            r2_det_reg  <= r1_det_reg;
            r2_zero_reg <= r1_zero_reg;
            r2_idx_reg  <= r1_idx_reg;
        end
        if (en_r3)
        begin
            // Magnitudes and result signs. The translation numerator is the
            // negated product, so its magnitude is that of the product and its
            // sign is set when the product is strictly positive.
            for (int j = 0; j < 3; j++)
            begin
                r3_absn_reg[j] <= r2_c_reg[j][CW-1] ? -(NW'(r2_c_reg[j]) <<< (2 * FRAC_BITS))
                                                    : (NW'(r2_c_reg[j]) <<< (2 * FRAC_BITS));
                r3_neg_reg[j]  <= r2_c_reg[j][CW-1] != r2_det_reg[DW-1];
            end
            r3_absn_reg[3] <= r2_tnum_reg[TW-1] ? -(NW'(r2_tnum_reg) <<< FRAC_BITS)
                                                : (NW'(r2_tnum_reg) <<< FRAC_BITS);
            r3_neg_reg[3]  <= ((r2_tnum_reg != '0) && !r2_tnum_reg[TW-1]) != r2_det_reg[DW-1];
            r3_absd_reg    <= r2_det_reg[DW-1] ? -r2_det_reg : r2_det_reg;
            r3_zero_reg    <= r2_zero_reg;
            r3_idx_reg     <= r2_idx_reg;
        end
        if (en_d[0])
        begin
            for (int l = 0; l < 4; l++)
            begin
                d_rem_reg[0][l] <= (RW'(r3_absn_reg[l]) << 1) + RW'(r3_absd_reg);
                d_q_reg[0][l]   <= '0;
                d_neg_reg[0][l] <= r3_neg_reg[l];
            end
            d_bot_reg[0]  <= RW'(r3_absd_reg) << 1;
            d_zero_reg[0] <= r3_zero_reg;
            d_idx_reg[0]  <= r3_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, four lanes, one quotient bit per stage.
    // ------------------------------------------------------------------
    for (genvar s = 1; s < NS; s++)
    begin : g_div
        localparam int B = NS - 1 - s;
        logic [RW-1:0] trial;
        assign trial = d_bot_reg[s-1] << B;

        always_ff @(posedge clk)
        begin
            if (en_d[s])
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (d_rem_reg[s-1][l] >= trial)
                    begin
                        d_rem_reg[s][l] <= d_rem_reg[s-1][l] - trial;
                        d_q_reg[s][l]   <= d_q_reg[s-1][l] | ((W+1)'(1) << B);
                    end
                    else
                    begin
                        d_rem_reg[s][l] <= d_rem_reg[s-1][l];
                        d_q_reg[s][l]   <= d_q_reg[s-1][l];
                    end
                    d_neg_reg[s][l] <= d_neg_reg[s-1][l];
                end
                d_bot_reg[s]  <= d_bot_reg[s-1];
                d_zero_reg[s] <= d_zero_reg[s-1];
                d_idx_reg[s]  <= d_idx_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate, zero a singular matrix, tag the row.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            o_beat_reg.row_index <= d_idx_reg[NS-1];
            o_beat_reg.singular  <= d_zero_reg[NS-1];
            o_beat_reg.last_row  <= (d_idx_reg[NS-1] == ROW_LAST);
            if (d_zero_reg[NS-1])
            begin
                o_beat_reg.col0 <= '0;
                o_beat_reg.col1 <= '0;
                o_beat_reg.col2 <= '0;
                o_beat_reg.col3 <= '0;
            end
            else
            begin
                o_beat_reg.col0 <= sat_q(d_q_reg[NS-1][0], d_neg_reg[NS-1][0]);
                o_beat_reg.col1 <= sat_q(d_q_reg[NS-1][1], d_neg_reg[NS-1][1]);
                o_beat_reg.col2 <= sat_q(d_q_reg[NS-1][2], d_neg_reg[NS-1][2]);
                o_beat_reg.col3 <= sat_q(d_q_reg[NS-1][3], d_neg_reg[NS-1][3]);
            end
        end
    end

    assign row_valid = o_v_reg;
    assign row = o_beat_reg;

endmodule

`default_nettype wire

/* hdl/amix_checker.sv */
// Port-level checks for affine_matrix_inverse_top, bound to it below.
// Uses amix_pkg for the beat types and row numbers.
`default_nettype none

module amix_checker
    import amix_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      mat_valid,
    input logic      mat_stall,
    input mat_beat_t mat,
    input logic      row_valid,
    input logic      row_stall,
    input row_beat_t row
);

    // Row number the next row beat should carry.
    logic [1:0] exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_reg <= ROW_FIRST;
        else if (row_valid && !row_stall)
            exp_reg <= row.last_row ? ROW_FIRST : exp_reg + 2'd1;
    end

    a_mat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_stall |=> mat_valid && $stable(mat))
        else $error("matrix beat changed while stalled");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_stall |=> row_valid && $stable(row))
        else $error("row beat changed while stalled");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row.row_index == exp_reg))
        else $error("row beats out of order");

    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row.last_row == (row.row_index == ROW_LAST)))
        else $error("last_row does not match row_index");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row.singular |->
            (row.col0 == '0) && (row.col1 == '0) && (row.col2 == '0) && (row.col3 == '0))
        else $error("singular row carries nonzero elements");

endmodule

bind affine_matrix_inverse_top amix_checker u_amix_checker (.*);

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for affine_matrix_inverse_top: random and directed matrices in,
// row beats checked against an exact wide-integer inverse computed here. Uses amix_pkg.
`default_nettype none

module tb;
    import amix_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] MINV = 32'sh8000_0000;

    // Wide enough for the scaled cofactors, the determinant and the translation sums.
    typedef logic signed [191:0] acc_t;
    typedef logic [191:0] uacc_t;

    logic      clk;
    logic      rst_n;
    logic      mat_valid;
    logic      mat_stall;
    mat_beat_t mat;
    logic      row_valid;
    logic      row_stall;
    row_beat_t row;

    row_beat_t rows_due[$];
    int        fail_count;
    int        mats_sent;
    int        rows_seen;
    int        singular_seen;
    int        cycle_count;
    bit        calm_sender;
    bit        calm_receiver;

    affine_matrix_inverse_top #(.FRAC_BITS(FRAC)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row       (row)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Rounded quotient, ties away from zero, saturated to the element range.
    function automatic logic [DATA_W-1:0] quot_round_sat(acc_t num, acc_t den);
        uacc_t n;
        uacc_t d;
        uacc_t q;
        uacc_t lim;
        bit    neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? uacc_t'(-num) : uacc_t'(num);
        d = (den < 0) ? uacc_t'(-den) : uacc_t'(den);
        q = (2 * n + d) / (2 * d);
        lim = uacc_t'(1) << (DATA_W - 1);
        if (neg)
        begin
            if (q > lim)
                q = lim;
            return DATA_W'(-q);
        end
        if (q > lim - 1)
            q = lim - 1;
        return q[DATA_W-1:0];
    endfunction

    // Pushes the three row beats that the inverse of one matrix should produce.
    task automatic expect_inverse(input mat_beat_t b);
        acc_t      m [3][4];
        acc_t      c [3][3];
        acc_t      det;
        acc_t      tsum;
        row_beat_t r;
        m[0][0] = b.a00; m[0][1] = b.a01; m[0][2] = b.a02; m[0][3] = b.a03;
        m[1][0] = b.a10; m[1][1] = b.a11; m[1][2] = b.a12; m[1][3] = b.a13;
        m[2][0] = b.a20; m[2][1] = b.a21; m[2][2] = b.a22; m[2][3] = b.a23;
        c[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
        c[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
        c[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
        c[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
        c[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
        c[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
        c[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
        c[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
        c[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
        det = m[0][0] * c[0][0] + m[0][1] * c[1][0] + m[0][2] * c[2][0];
        for (int i = 0; i < 3; i++)
        begin
            r = '0;
            r.row_index = 2'(i);
            r.last_row = (2'(i) == ROW_LAST);
            r.singular = (det == 0);
            if (det != 0)
            begin
                r.col0 = quot_round_sat(c[i][0] <<< (2 * FRAC), det);
                r.col1 = quot_round_sat(c[i][1] <<< (2 * FRAC), det);
                r.col2 = quot_round_sat(c[i][2] <<< (2 * FRAC), det);
                tsum = c[i][0] * m[0][3] + c[i][1] * m[1][3] + c[i][2] * m[2][3];
                r.col3 = quot_round_sat(-(tsum <<< FRAC), det);
            end
            rows_due.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one matrix beat, records its expected rows, then idles for a random gap.
    // Valid stays high across back-to-back beats.
    task automatic send_matrix(input mat_beat_t b);
        int gap;
        mat <= b;
        mat_valid <= 1'b1;
        @(posedge clk);
        while (mat_stall)
            @(posedge clk);
        expect_inverse(b);
        mats_sent++;
        gap = calm_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            mat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic mat_beat_t diag_matrix(logic signed [DATA_W-1:0] s0,
                                              logic signed [DATA_W-1:0] s1,
                                              logic signed [DATA_W-1:0] s2);
        mat_beat_t b;
        b = '0;
        b.a00 = s0;
        b.a11 = s1;
        b.a22 = s2;
        return b;
    endfunction

    // Element with a magnitude of a few units, so that inverses stay in range.
    function automatic logic signed [DATA_W-1:0] modest_elem();
        return $signed(DATA_W'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
    endfunction

    function automatic mat_beat_t random_matrix();
        mat_beat_t b;
        int        kind;
        kind = $urandom_range(0, 9);
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 5)
        begin
            // Well-conditioned linear part with wild translations.
            b.a00 = modest_elem(); b.a01 = modest_elem(); b.a02 = modest_elem();
            b.a10 = modest_elem(); b.a11 = modest_elem(); b.a12 = modest_elem();
            b.a20 = modest_elem(); b.a21 = modest_elem(); b.a22 = modest_elem();
        end
        else if (kind < 7)
        begin
            // Rows two and three repeat row one up to sign: determinant is zero.
            b.a10 = b.a00; b.a11 = b.a01; b.a12 = b.a02;
            b.a20 = -b.a00; b.a21 = -b.a01; b.a22 = -b.a02;
        end
        else if (kind == 7)
        begin
            // Tiny scale factors drive the inverse into saturation.
            b.a00 = $urandom_range(1, 300); b.a11 = -$urandom_range(1, 300);
            b.a22 = $urandom_range(1, 300);
            b.a01 = 0; b.a02 = 0; b.a10 = 0; b.a12 = 0; b.a20 = 0; b.a21 = 0;
        end
        return b;
    endfunction

    task automatic test_directed();
        mat_beat_t b;
        send_matrix(diag_matrix(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix({12{MAXV}});
        send_matrix({12{MINV}});
        send_matrix(diag_matrix(MINV, MINV, MINV));
        send_matrix(diag_matrix(MAXV, MINV, MAXV));
        send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag_matrix(-32'sd1, 32'sd3, -32'sd7));
        // A translation of half an LSB after scaling: checks rounding away from zero.
        b = diag_matrix(2 * ONE, 2 * ONE, -2 * ONE);
        b.a03 = 32'sd1; b.a13 = -32'sd1; b.a23 = 32'sd3;
        send_matrix(b);
        b = diag_matrix(2 * ONE, ONE, ONE);
        b.a03 = MAXV; b.a13 = MINV; b.a23 = MAXV;
        send_matrix(b);
        b = diag_matrix(32'sd16, 32'sd16, 32'sd16);
        b.a03 = MAXV; b.a13 = MINV; b.a23 = 32'sd5;
        send_matrix(b);
        // Axis permutation: inverse is the transpose.
        b = '0;
        b.a01 = ONE; b.a12 = -ONE; b.a20 = ONE;
        b.a03 = 3 * ONE; b.a13 = -5 * ONE; b.a23 = 7;
        send_matrix(b);
        b = {12{32'sh5555_5555}};
        send_matrix(b);
        b = diag_matrix(ONE / 2, 4 * ONE, -ONE / 4);
        b.a01 = ONE; b.a21 = -3 * ONE;
        b.a03 = MINV; b.a13 = MINV; b.a23 = MINV;
        send_matrix(b);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            calm_sender = (i % 100) >= 80;
            calm_receiver = (i % 150) >= 120;
            send_matrix(random_matrix());
        end
        calm_sender = 1'b0;
        calm_receiver = 1'b0;
    endtask

    // The sender holds off until the block has delivered every row it owes.
    task automatic test_drain_pause();
        mat_valid <= 1'b0;
        @(posedge clk);
        while (rows_due.size() != 0)
            @(posedge clk);
        test_random(20);
    endtask

    // Row beats are compared in order against the expected queue.
    always @(posedge clk)
    begin
        row_beat_t want;
        if (rst_n && row_valid && !row_stall)
        begin
            rows_seen++;
            if (rows_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected row beat %p", $time, row);
            end
            else
            begin
                want = rows_due.pop_front();
                if (row.singular)
                    singular_seen++;
                if (row.row_index !== want.row_index)
                    $display("%0t: row_index expected %0d got %0d", $time,
                             want.row_index, row.row_index);
                if (row.col0 !== want.col0)
                    $display("%0t: col0 expected %h got %h", $time, want.col0, row.col0);
                if (row.col1 !== want.col1)
                    $display("%0t: col1 expected %h got %h", $time, want.col1, row.col1);
                if (row.col2 !== want.col2)
                    $display("%0t: col2 expected %h got %h", $time, want.col2, row.col2);
                if (row.col3 !== want.col3)
                    $display("%0t: col3 expected %h got %h", $time, want.col3, row.col3);
                if (row.singular !== want.singular)
                    $display("%0t: singular expected %b got %b", $time,
                             want.singular, row.singular);
                if (row.last_row !== want.last_row)
                    $display("%0t: last_row expected %b got %b", $time,
                             want.last_row, row.last_row);
                if (row !== want)
                    fail_count++;
            end
        end
    end

    // The receiver stalls at random: mostly short bursts, now and then a long one.
    always @(posedge clk)
    begin
        int stall_left;
        if (!rst_n || calm_receiver)
        begin
            stall_left = 0;
            row_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            row_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            row_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        fail_count = 0;
        mats_sent = 0;
        rows_seen = 0;
        singular_seen = 0;
        cycle_count = 0;
        calm_sender = 1'b0;
        calm_receiver = 1'b0;
        rst_n = 1'b0;
        mat_valid = 1'b0;
        mat = '0;
        row_stall = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(230);
        test_drain_pause();
        test_random(215);

        mat_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        // Let any stray beat surface past the pipeline latency.
        repeat (80) @(posedge clk);

        $display("Inverted %0d matrices, checked %0d row beats, %0d of them singular.",
                 mats_sent, rows_seen, singular_seen);
        $display("Covered identity, zero, extreme, tiny and random matrices under stalls.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
